/* rtl/biou_pkg.sv */
// shared types and constants for the box overlap (iou) core
// used by biou_serial_div and box_iou_best_match_core; depends on nothing
package biou_pkg;

  localparam int COORD_BITS     = 16;
  localparam int FRAC_BITS      = 16;
  localparam int MAX_CANDIDATES = 4096;

  localparam int OVL_BITS  = FRAC_BITS + 1;
  localparam int IDX_BITS  = 13;
  // box side length incl. the +1, signed: covers 2^COORD_BITS and inverted boxes
  localparam int SPAN_BITS = COORD_BITS + 2;
  localparam int PROD_BITS = 2 * SPAN_BITS;
  // union is a sum of three products
  localparam int UNI_BITS  = PROD_BITS + 2;

  localparam logic [OVL_BITS-1:0] IOU_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  localparam logic CMD_PAIR = 1'b0;
  localparam logic CMD_BEST = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] a_left;
    logic signed [COORD_BITS-1:0] a_top;
    logic signed [COORD_BITS-1:0] a_right;
    logic signed [COORD_BITS-1:0] a_bottom;
    logic signed [COORD_BITS-1:0] b_left;
    logic signed [COORD_BITS-1:0] b_top;
    logic signed [COORD_BITS-1:0] b_right;
    logic signed [COORD_BITS-1:0] b_bottom;
    logic                         last;
  } req_t;

  typedef struct packed {
    logic [OVL_BITS-1:0] overlap;
    logic [IDX_BITS-1:0] best_index;
    logic                found;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_UNION,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/biou_serial_div.sv */
// restoring bit-serial divider, one quotient bit per cycle, msb first
// expects num < den; uses biou_pkg for the status struct
module biou_serial_div #(
  parameter int DEN_BITS  = biou_pkg::UNI_BITS,
  parameter int QUOT_BITS = biou_pkg::FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DEN_BITS-1:0]      num,
  input  logic [DEN_BITS-1:0]      den,
  output logic [QUOT_BITS-1:0]     quot,
  output biou_pkg::div_stat_t      stat
);

  localparam int CNT_BITS = $clog2(QUOT_BITS);

  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] dvs;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;

  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;
  logic                take;
  logic [DEN_BITS-1:0] rem_next;

  always_comb begin
    trial    = {rem, 1'b0};
    diff     = trial - {1'b0, dvs};
    take     = !diff[DEN_BITS];
    // remainder stays below the divisor, so the top bit drops out
    rem_next = take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(QUOT_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dvs  <= den;
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= {quot[QUOT_BITS-2:0], take};
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

/* rtl/box_iou_best_match_core.sv */
// box overlap core: iou of two inclusive boxes, pairwise or as a best-match run
// a request passes setup, the multiplier steps, union, check, the bit-serial divider (one
// bit a cycle) and finish; the divider is skipped when the boxes miss, the intersection or
// union is not positive or the overlap saturates; new requests are taken only in idle
// synchronous reset clears the controller, the result valid flag and the run state
// depends on biou_pkg and biou_serial_div
module box_iou_best_match_core #(
  parameter int MAX_CANDIDATES = biou_pkg::MAX_CANDIDATES
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  biou_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output biou_pkg::res_t res
);

  localparam int SPAN_BITS = biou_pkg::SPAN_BITS;
  localparam int PROD_BITS = biou_pkg::PROD_BITS;
  localparam int UNI_BITS  = biou_pkg::UNI_BITS;
  localparam int OVL_BITS  = biou_pkg::OVL_BITS;
  localparam int IDX_BITS  = biou_pkg::IDX_BITS;
  localparam int FRAC_BITS = biou_pkg::FRAC_BITS;
  localparam int CRD_BITS  = biou_pkg::COORD_BITS;

  // shared multiplier schedule
  localparam logic [1:0] MUL_INTER  = 2'd0;
  localparam logic [1:0] MUL_AREA_A = 2'd1;
  localparam logic [1:0] MUL_AREA_B = 2'd2;

  biou_pkg::state_t state, state_next;
  biou_pkg::req_t   cur;

  logic [1:0] mstep;
  logic signed [SPAN_BITS-1:0] cw, ch, wa, ha, wb, hb;
  logic                        disjoint;
  logic signed [PROD_BITS-1:0] inter, area_a, area_b;
  logic signed [UNI_BITS-1:0]  uni;
  logic                        zero, sat;

  logic [OVL_BITS-1:0] running_best;
  logic [IDX_BITS-1:0] running_index;
  logic [IDX_BITS-1:0] cand_count;

  logic                div_start;
  logic [FRAC_BITS-1:0] div_quot;
  biou_pkg::div_stat_t div_stat;

  // ---------------- setup: overlap and side lengths ----------------
  logic signed [CRD_BITS-1:0] max_l, max_t, min_r, min_b;
  logic                       disjoint_next;
  logic signed [SPAN_BITS-1:0] cw_next, ch_next, wa_next, ha_next, wb_next, hb_next;

  always_comb begin
    max_l = (cur.a_left  > cur.b_left)   ? cur.a_left  : cur.b_left;
    max_t = (cur.a_top   > cur.b_top)    ? cur.a_top   : cur.b_top;
    min_r = (cur.a_right < cur.b_right)  ? cur.a_right : cur.b_right;
    min_b = (cur.a_bottom < cur.b_bottom) ? cur.a_bottom : cur.b_bottom;
    disjoint_next = (cur.a_left > cur.b_right) || (cur.a_top > cur.b_bottom) ||
                    (cur.a_right < cur.b_left) || (cur.a_bottom < cur.b_top);
    cw_next = SPAN_BITS'(min_r) - SPAN_BITS'(max_l) + SPAN_BITS'(1);
    ch_next = SPAN_BITS'(min_b) - SPAN_BITS'(max_t) + SPAN_BITS'(1);
    wa_next = SPAN_BITS'(cur.a_right) - SPAN_BITS'(cur.a_left) + SPAN_BITS'(1);
    ha_next = SPAN_BITS'(cur.a_bottom) - SPAN_BITS'(cur.a_top) + SPAN_BITS'(1);
    wb_next = SPAN_BITS'(cur.b_right) - SPAN_BITS'(cur.b_left) + SPAN_BITS'(1);
    hb_next = SPAN_BITS'(cur.b_bottom) - SPAN_BITS'(cur.b_top) + SPAN_BITS'(1);
  end

  // ---------------- one multiplier, three products ----------------
  logic signed [SPAN_BITS-1:0] op_a, op_b;
  logic signed [PROD_BITS-1:0] prod;

  always_comb begin
    case (mstep)
      MUL_INTER:  begin op_a = cw; op_b = ch; end
      MUL_AREA_A: begin op_a = wa; op_b = ha; end
      default:    begin op_a = wb; op_b = hb; end
    endcase
    prod = op_a * op_b;
  end

  // ---------------- check and result value ----------------
  logic zero_next, sat_next;
  logic [OVL_BITS-1:0] iou;

  always_comb begin
    zero_next = disjoint || (uni <= UNI_BITS'(0)) || (inter <= PROD_BITS'(0));
    sat_next  = UNI_BITS'(inter) >= uni;
    if (zero)      iou = '0;
    else if (sat)  iou = biou_pkg::IOU_ONE;
    else           iou = {1'b0, div_quot};
  end

  // ---------------- best-match bookkeeping ----------------
  logic                cand_room, better;
  logic [IDX_BITS-1:0] cand_inc, cnt_upd, idx_upd;
  logic [OVL_BITS-1:0] best_upd;
  logic                need_out, res_free;
  biou_pkg::res_t      res_data;

  always_comb begin
    cand_room = int'(cand_count) < MAX_CANDIDATES;
    cand_inc  = cand_count + 1'b1;
    better    = cand_room && (iou > running_best);
    cnt_upd   = cand_room ? cand_inc : cand_count;
    idx_upd   = better ? cand_inc : running_index;
    best_upd  = better ? iou : running_best;
    need_out  = (cur.cmd == biou_pkg::CMD_PAIR) || cur.last;
    res_free  = !res_valid || res_ready;
    if (cur.cmd == biou_pkg::CMD_PAIR) begin
      res_data = '{overlap: iou, best_index: '0, found: 1'b0};
    end else begin
      res_data = '{overlap: best_upd, best_index: idx_upd, found: (idx_upd != '0)};
    end
  end

  // ---------------- controller ----------------
  logic commit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= biou_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    unique case (state)
      biou_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) state_next = biou_pkg::ST_SETUP;
      end
      biou_pkg::ST_SETUP: begin
        state_next = biou_pkg::ST_MUL;
      end
      biou_pkg::ST_MUL: begin
        if (mstep == MUL_AREA_B) state_next = biou_pkg::ST_UNION;
      end
      biou_pkg::ST_UNION: begin
        state_next = biou_pkg::ST_CHECK;
      end
      biou_pkg::ST_CHECK: begin
        if (zero_next || sat_next) begin
          state_next = biou_pkg::ST_FINISH;
        end else begin
          div_start  = 1'b1;
          state_next = biou_pkg::ST_DIV;
        end
      end
      biou_pkg::ST_DIV: begin
        if (div_stat.done) state_next = biou_pkg::ST_FINISH;
      end
      biou_pkg::ST_FINISH: begin
        // hold here while an earlier result still waits downstream
        if (!need_out || res_free) begin
          commit     = 1'b1;
          state_next = biou_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = biou_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) cur <= req;
    if (state == biou_pkg::ST_SETUP) begin
      disjoint <= disjoint_next;
      cw <= cw_next;
      ch <= ch_next;
      wa <= wa_next;
      ha <= ha_next;
      wb <= wb_next;
      hb <= hb_next;
    end
    if (state == biou_pkg::ST_MUL) begin
      case (mstep)
        MUL_INTER:  inter  <= prod;
        MUL_AREA_A: area_a <= prod;
        default:    area_b <= prod;
      endcase
    end
    if (state == biou_pkg::ST_UNION) begin
      uni <= UNI_BITS'(area_a) + UNI_BITS'(area_b) - UNI_BITS'(inter);
    end
    if (state == biou_pkg::ST_CHECK) begin
      zero <= zero_next;
      sat  <= sat_next;
    end
    if (commit && need_out) res <= res_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstep         <= MUL_INTER;
      res_valid     <= 1'b0;
      running_best  <= '0;
      running_index <= '0;
      cand_count    <= '0;
    end else begin
      if (state == biou_pkg::ST_MUL) mstep <= mstep + 1'b1;
      else                           mstep <= MUL_INTER;
      if (commit && need_out)  res_valid <= 1'b1;
      else if (res_ready)      res_valid <= 1'b0;
      if (commit && (cur.cmd == biou_pkg::CMD_BEST)) begin
        if (cur.last) begin
          running_best  <= '0;
          running_index <= '0;
          cand_count    <= '0;
        end else begin
          running_best  <= best_upd;
          running_index <= idx_upd;
          cand_count    <= cnt_upd;
        end
      end
    end
  end

  biou_serial_div #(
    .DEN_BITS  (UNI_BITS),
    .QUOT_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (UNI_BITS'(inter)),
    .den   (uni),
    .quot  (div_quot),
    .stat  (div_stat)
  );

`ifndef SYNTHESIS
  a_accept_setup: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == biou_pkg::ST_SETUP))
    else $error("request accepted but setup did not follow");

  a_found_index: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.found == (res.best_index != '0)))
    else $error("found flag disagrees with best index");

  a_overlap_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.overlap <= biou_pkg::IOU_ONE))
    else $error("overlap above one");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == biou_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule
